// ----- hdl/bavg_pkg.sv -----
// shared constants and types for the block average downscaler
package bavg_pkg;

  // sizing
  localparam int unsigned MAX_WIDTH    = 2048;
  localparam int unsigned MAX_BLOCK    = 4;
  localparam int unsigned HEIGHT_LIMIT = 2048;

  // fixed field widths
  localparam int unsigned NCH       = 3;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned BS_W      = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ROW_W     = 11;
  localparam int unsigned OUT_POS_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // derived widths
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned BLK_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned BSE_W   = $clog2(MAX_BLOCK + 1) + 1;
  localparam int unsigned CNT_MAX = MAX_BLOCK * MAX_BLOCK;
  localparam int unsigned CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX + 1) : 1;
  localparam int unsigned CNT_N   = 1 << CNT_W;
  localparam int unsigned SUM_W   = PIX_W + $clog2(CNT_MAX);
  localparam int unsigned RECIP_K = SUM_W + $clog2(CNT_MAX);
  localparam int unsigned RECIP_W = RECIP_K + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned CMP_W   = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

  typedef logic [NCH-1:0][SUM_W-1:0] sum3_t;
  typedef logic [NCH-1:0][PIX_W-1:0] pix3_t;

  // per-pixel bookkeeping from the position tracker
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             first;
    logic             emit;
    logic             last;
    logic [CNT_W-1:0] count;
  } pix_info_t;

endpackage

// ----- hdl/bavg_sum_ram.sv -----
// column sum memory: one write port, one registered read port
module bavg_sum_ram
  import bavg_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  sum3_t            wdata,
  input  logic             re,
  input  logic [COL_W-1:0] raddr,
  output sum3_t            rdata
);

  sum3_t mem [MAX_WIDTH];
  sum3_t rdata_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bavg_pos.sv -----
// configuration registers and raster position tracking
module bavg_pos
  import bavg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 step,
  output pix_info_t            info
);

  logic [BS_W-1:0]  block_size_r;
  logic [CFG_W-1:0] image_width_r;
  logic [CFG_W-1:0] image_height_r;
  logic [COL_W-1:0] pixel_x_r;
  logic [ROW_W-1:0] pixel_y_r;
  logic [BLK_W-1:0] col_in_blk_r;
  logic [BLK_W-1:0] row_in_blk_r;
  logic [COL_W-1:0] blk_col_r;
  logic [ROW_W-1:0] blk_row_r;

  logic [BSE_W-1:0] bs_eff;
  logic [CMP_W-1:0] w_eff;
  logic [CMP_W-1:0] h_eff;
  logic             last_x;
  logic             last_y;
  logic             cib_end;
  logic             rib_end;
  logic [BLK_W:0]   cib_p1;
  logic [BLK_W:0]   rib_p1;

  // clamp the registers to their usable ranges
  always_comb begin
    if (block_size_r == '0) begin
      bs_eff = BSE_W'(1);
    end else if (BSE_W'(block_size_r) > BSE_W'(MAX_BLOCK)) begin
      bs_eff = BSE_W'(MAX_BLOCK);
    end else begin
      bs_eff = BSE_W'(block_size_r);
    end
    if (image_width_r == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(image_width_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = CMP_W'(1);
    end else if (CMP_W'(image_height_r) > CMP_W'(HEIGHT_LIMIT)) begin
      h_eff = CMP_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = CMP_W'(image_height_r);
    end
  end

  // edge and block boundary flags for the current pixel
  always_comb begin
    cib_p1  = {1'b0, col_in_blk_r} + 1'b1;
    rib_p1  = {1'b0, row_in_blk_r} + 1'b1;
    last_x  = (CMP_W'(pixel_x_r) + CMP_W'(1)) >= w_eff;
    last_y  = (CMP_W'(pixel_y_r) + CMP_W'(1)) >= h_eff;
    cib_end = BSE_W'(cib_p1) >= bs_eff;
    rib_end = BSE_W'(rib_p1) >= bs_eff;
    info.col   = blk_col_r;
    info.row   = blk_row_r;
    info.first = (col_in_blk_r == '0) && (row_in_blk_r == '0);
    info.emit  = (last_x || cib_end) && (last_y || rib_end);
    info.last  = last_x && last_y;
    info.count = CNT_W'(CNT_W'(cib_p1) * CNT_W'(rib_p1));
  end

  // register writes restart the frame, accepted pixels advance the raster
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r   <= BS_W'(1);
      image_width_r  <= CFG_W'(2048);
      image_height_r <= CFG_W'(2048);
      pixel_x_r      <= '0;
      pixel_y_r      <= '0;
      col_in_blk_r   <= '0;
      row_in_blk_r   <= '0;
      blk_col_r      <= '0;
      blk_row_r      <= '0;
    end else if (cfg_we && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_IMAGE_WIDTH ||
                            cfg_index == REG_IMAGE_HEIGHT)) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE:   block_size_r   <= cfg_wdata[BS_W-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
      pixel_x_r    <= '0;
      pixel_y_r    <= '0;
      col_in_blk_r <= '0;
      row_in_blk_r <= '0;
      blk_col_r    <= '0;
      blk_row_r    <= '0;
    end else if (step) begin
      if (last_x) begin
        pixel_x_r    <= '0;
        col_in_blk_r <= '0;
        blk_col_r    <= '0;
        if (last_y) begin
          pixel_y_r    <= '0;
          row_in_blk_r <= '0;
          blk_row_r    <= '0;
        end else begin
          pixel_y_r <= pixel_y_r + 1'b1;
          if (rib_end) begin
            row_in_blk_r <= '0;
            blk_row_r    <= blk_row_r + 1'b1;
          end else begin
            row_in_blk_r <= rib_p1[BLK_W-1:0];
          end
        end
      end else begin
        pixel_x_r <= pixel_x_r + 1'b1;
        if (cib_end) begin
          col_in_blk_r <= '0;
          blk_col_r    <= blk_col_r + 1'b1;
        end else begin
          col_in_blk_r <= cib_p1[BLK_W-1:0];
        end
      end
    end
  end

  // position stays inside the block and the column inside the image
  a_cib_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    BSE_W'(col_in_blk_r) < bs_eff)
    else $error("column offset outside block");
  a_rib_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    BSE_W'(row_in_blk_r) < bs_eff)
    else $error("row offset outside block");
  a_x_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(pixel_x_r) < w_eff)
    else $error("pixel column outside image");

endmodule

// ----- hdl/bavg_div.sv -----
// reciprocal lookup and multiply stage, then the output register
module bavg_div
  import bavg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  sum3_t                sums,
  input  pix_info_t            info,
  output logic                 out_v,
  output pix3_t                avg,
  output logic [OUT_POS_W-1:0] col,
  output logic [OUT_POS_W-1:0] row,
  output logic                 last
);

  logic [RECIP_W-1:0] recip_tab [CNT_N];

  logic                 s2_v_r;
  sum3_t                s2_sum_r;
  logic [RECIP_W-1:0]   s2_recip_r;
  logic [OUT_POS_W-1:0] s2_col_r;
  logic [OUT_POS_W-1:0] s2_row_r;
  logic                 s2_last_r;

  logic                 out_v_r;
  pix3_t                avg_r;
  logic [OUT_POS_W-1:0] col_r;
  logic [OUT_POS_W-1:0] row_r;
  logic                 last_r;

  logic [NCH-1:0][PROD_W-1:0] prod;

  // ceil(2^k / d) for every pixel count d
  assign recip_tab[0] = '0;
  for (genvar Dv = 1; Dv < CNT_N; Dv++) begin : g_recip
    localparam int unsigned RV = ((1 << RECIP_K) + Dv - 1) / Dv;
    assign recip_tab[Dv] = RECIP_W'(RV);
  end

  // sum times reciprocal gives the truncated mean
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      prod[k] = PROD_W'(s2_sum_r[k]) * PROD_W'(s2_recip_r);
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r  <= in_v;
      out_v_r <= s2_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en && in_v) begin
      s2_sum_r   <= sums;
      s2_recip_r <= recip_tab[info.count];
      s2_col_r   <= OUT_POS_W'(info.col);
      s2_row_r   <= OUT_POS_W'(info.row);
      s2_last_r  <= info.last;
    end
    if (en && s2_v_r) begin
      for (int k = 0; k < NCH; k++) begin
        avg_r[k] <= prod[k][RECIP_K +: PIX_W];
      end
      col_r  <= s2_col_r;
      row_r  <= s2_row_r;
      last_r <= s2_last_r;
    end
  end

  assign out_v = out_v_r;
  assign avg   = avg_r;
  assign col   = col_r;
  assign row   = row_r;
  assign last  = last_r;

endmodule

// ----- hdl/block_average_downscale_core.sv -----
// Block average downscaler: one pixel word per clock in, one mean word per
// block out. The pipeline takes one input word every clock while the output
// side is not stalled; a result passes the read, divider and output stage
// registers. Running channel sums for the current block row sit in a
// 2048 x 36 memory with one read and one write port, read when a pixel is
// accepted and written back, with a one-word bypass for back-to-back pixels
// of the same block column. The first pixel of a block overwrites its entry,
// so the memory needs no clearing after reset. Register writes restart the
// frame at pixel (0,0); the user must issue them only while idle (unchecked).
module block_average_downscale_core
  import bavg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_channel0,
  input  logic [PIX_W-1:0]     in_channel1,
  input  logic [PIX_W-1:0]     in_channel2,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_avg0,
  output logic [PIX_W-1:0]     out_avg1,
  output logic [PIX_W-1:0]     out_avg2,
  output logic [OUT_POS_W-1:0] out_col,
  output logic [OUT_POS_W-1:0] out_row,
  output logic                 out_frame_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic      adv;
  logic      acc;
  pix_info_t info;
  sum3_t     rd_data;
  sum3_t     base;
  sum3_t     new_sum;
  pix3_t     avg;

  logic      s1_v_r;
  pix3_t     s1_pix_r;
  pix_info_t s1_info_r;
  logic      byp_r;
  sum3_t     byp_data_r;

  // whole pipeline moves when the output register can take a word
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  bavg_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (acc),
    .info      (info)
  );

  bavg_sum_ram u_ram (
    .clk   (clk),
    .we    (adv && s1_v_r),
    .waddr (s1_info_r.col),
    .wdata (new_sum),
    .re    (acc),
    .raddr (info.col),
    .rdata (rd_data)
  );

  // accumulate, taking the word just written when it hit the same column
  always_comb begin
    base = byp_r ? byp_data_r : rd_data;
    for (int k = 0; k < NCH; k++) begin
      new_sum[k] = s1_info_r.first ? SUM_W'(s1_pix_r[k])
                                   : base[k] + SUM_W'(s1_pix_r[k]);
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      byp_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      byp_r  <= acc && s1_v_r && (info.col == s1_info_r.col);
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= {in_channel2, in_channel1, in_channel0};
      s1_info_r <= info;
    end
    if (adv && s1_v_r) begin
      byp_data_r <= new_sum;
    end
  end

  bavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .in_v  (s1_v_r && s1_info_r.emit),
    .sums  (new_sum),
    .info  (s1_info_r),
    .out_v (out_valid),
    .avg   (avg),
    .col   (out_col),
    .row   (out_row),
    .last  (out_frame_last)
  );

  assign out_avg0 = avg[0];
  assign out_avg1 = avg[1];
  assign out_avg2 = avg[2];

  // bypass only ever stands for a word that is in the read stage
  a_byp_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> s1_v_r)
    else $error("bypass set without a word in the read stage");

endmodule
